FILE: rtl/core/signed_radix_digit_emitter_macros.svh
// Assertion macros shared by the emitter RTL.
`ifndef SIGNED_RADIX_DIGIT_EMITTER_MACROS_SVH
`define SIGNED_RADIX_DIGIT_EMITTER_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define SRDE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: assertion failed");

// The condition must never be true outside reset.
`define SRDE_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define SRDE_ASSERT(lbl, clk, rstn, prop)
`define SRDE_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

FILE: rtl/core/srde_pkg.sv
`timescale 1ns / 1ps

package srde_pkg;

  localparam int MAX_RADIX_DEF  = 16;
  localparam int VALUE_BITS_DEF = 32;

  // Restoring division steps done in one cycle.
  localparam int STEPS_PER_CYCLE = 8;

  localparam int RADIX_W = 5;
  localparam int CHARS_W = 64;
  localparam int TABLE_W = 2 * CHARS_W;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [RADIX_W-1:0] RESET_RADIX      = 5'd16;
  localparam logic [CHARS_W-1:0] RESET_CHARS_LOW  = 64'h3736353433323130;
  localparam logic [CHARS_W-1:0] RESET_CHARS_HIGH = 64'h6665646362613938;

  // Register indexes, taken from bits [4:3] of the byte address.
  localparam logic [1:0] REG_RADIX      = 2'd0;
  localparam logic [1:0] REG_CHARS_LOW  = 2'd1;
  localparam logic [1:0] REG_CHARS_HIGH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_SIGN,
    ST_DIGIT,
    ST_ERR
  } ctrl_state_e;

  typedef enum logic [1:0] {
    OUT_SIGN,
    OUT_DIGIT,
    OUT_ERR
  } out_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_step;
    logic     push;
    logic     pop;
    out_sel_e out_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic neg;
    logic quot_zero;
    logic last_pass;
    logic cnt_one;
  } dp_status_t;

  function automatic logic [7:0] table_char(input logic [TABLE_W-1:0] tbl,
                                            input logic [3:0] pos);
    table_char = tbl[{pos, 3'b000} +: 8];
  endfunction

endpackage

FILE: rtl/core/srde_cfg.sv
`timescale 1ns / 1ps

`include "signed_radix_digit_emitter_macros.svh"

module srde_cfg #(
  parameter int MAX_RADIX = srde_pkg::MAX_RADIX_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [4:0]                      paddr,
  input  logic [srde_pkg::CHARS_W-1:0]    pwdata,
  output logic [srde_pkg::CHARS_W-1:0]    prdata,
  output logic                            pready,
  output logic [srde_pkg::RADIX_W-1:0]    radix_o,
  output logic [srde_pkg::TABLE_W-1:0]    table_o,
  output logic                            table_ok_o
);

  logic [srde_pkg::RADIX_W-1:0] radix_q, radix_d;
  logic [srde_pkg::CHARS_W-1:0] low_q, low_d;
  logic [srde_pkg::CHARS_W-1:0] high_q, high_d;
  logic                         wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    radix_d = radix_q;
    low_d   = low_q;
    high_d  = high_q;
    if (wr_en) begin
      case (paddr[4:3])
        srde_pkg::REG_RADIX:      radix_d = pwdata[srde_pkg::RADIX_W-1:0];
        srde_pkg::REG_CHARS_LOW:  low_d   = pwdata;
        srde_pkg::REG_CHARS_HIGH: high_d  = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= srde_pkg::RESET_RADIX;
      low_q   <= srde_pkg::RESET_CHARS_LOW;
      high_q  <= srde_pkg::RESET_CHARS_HIGH;
    end else begin
      radix_q <= radix_d;
      low_q   <= low_d;
      high_q  <= high_d;
    end
  end

  always_comb begin
    case (paddr[4:3])
      srde_pkg::REG_RADIX:      prdata = {{(srde_pkg::CHARS_W-srde_pkg::RADIX_W){1'b0}},
                                          radix_q};
      srde_pkg::REG_CHARS_LOW:  prdata = low_q;
      srde_pkg::REG_CHARS_HIGH: prdata = high_q;
      default:                  prdata = '0;
    endcase
  end

  assign radix_o = radix_q;
  assign table_o = {high_q, low_q};

  // Only the first radix characters take part in the check.
  always_comb begin
    logic [7:0] ca;
    logic       ok;
    ok = (radix_q >= srde_pkg::RADIX_W'(2)) &&
         (radix_q <= srde_pkg::RADIX_W'(MAX_RADIX));
    for (int a = 0; a < 16; a++) begin
      ca = srde_pkg::table_char(table_o, 4'(a));
      if (srde_pkg::RADIX_W'(a) < radix_q) begin
        if (ca == srde_pkg::CHAR_NUL || ca == srde_pkg::CHAR_PLUS ||
            ca == srde_pkg::CHAR_MINUS) begin
          ok = 1'b0;
        end
        for (int b = a + 1; b < 16; b++) begin
          if (srde_pkg::RADIX_W'(b) < radix_q &&
              srde_pkg::table_char(table_o, 4'(b)) == ca) begin
            ok = 1'b0;
          end
        end
      end
    end
    table_ok_o = ok;
  end

endmodule

FILE: rtl/core/srde_dpath.sv
`timescale 1ns / 1ps

`include "signed_radix_digit_emitter_macros.svh"

module srde_dpath #(
  parameter int MAX_RADIX  = srde_pkg::MAX_RADIX_DEF,
  parameter int VALUE_BITS = srde_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  srde_pkg::ctrl_cmd_t          cmd_i,
  output srde_pkg::dp_status_t         status_o,
  input  logic [VALUE_BITS-1:0]        value_i,
  input  logic [srde_pkg::RADIX_W-1:0] radix_i,
  input  logic [srde_pkg::TABLE_W-1:0] table_i,
  output logic [7:0]                   out_char_o
);

  localparam int STEPS  = srde_pkg::STEPS_PER_CYCLE;
  localparam int PASSES = (VALUE_BITS + STEPS - 1) / STEPS;
  localparam int DIV_W  = PASSES * STEPS;
  localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam int DIG_W  = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int DEPTH  = VALUE_BITS;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  logic [DIV_W-1:0]      quot_q, quot_d;
  logic [DIG_W-1:0]      rem_q, rem_d;
  logic                  neg_q;
  logic [PASS_W-1:0]     pass_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIG_W-1:0]      stk_q [DEPTH];
  logic [VALUE_BITS-1:0] mag;
  logic [DIG_W:0]        rad;

  assign mag = value_i[VALUE_BITS-1] ? (~value_i + VALUE_BITS'(1)) : value_i;
  assign rad = radix_i[DIG_W:0];

  // Eight restoring division steps on the narrow remainder per cycle.
  always_comb begin
    logic [DIG_W:0]   t;
    logic [DIV_W-1:0] q;
    logic [DIG_W-1:0] r;
    q = quot_q;
    r = rem_q;
    for (int i = 0; i < STEPS; i++) begin
      t = {r, q[DIV_W-1]};
      q = {q[DIV_W-2:0], 1'b0};
      if (t >= rad) begin
        t    = t - rad;
        q[0] = 1'b1;
      end
      r = t[DIG_W-1:0];
    end
    quot_d = q;
    rem_d  = r;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quot_q <= DIV_W'(mag);
      rem_q  <= '0;
      neg_q  <= value_i[VALUE_BITS-1];
    end else if (cmd_i.div_step) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end else if (cmd_i.push) begin
      rem_q <= '0;
    end

    if (cmd_i.push) begin
      stk_q[0] <= rem_q;
      for (int i = 1; i < DEPTH; i++) begin
        stk_q[i] <= stk_q[i-1];
      end
    end else if (cmd_i.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        stk_q[i] <= stk_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.load || cmd_i.push) begin
        pass_q <= '0;
      end else if (cmd_i.div_step) begin
        pass_q <= pass_q + PASS_W'(1);
      end

      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.push) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.pop) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  assign status_o.neg       = neg_q;
  assign status_o.quot_zero = (quot_q == '0);
  assign status_o.last_pass = (pass_q == PASS_W'(PASSES - 1));
  assign status_o.cnt_one   = (cnt_q == CNT_W'(1));

  always_comb begin
    case (cmd_i.out_sel)
      srde_pkg::OUT_SIGN:  out_char_o = srde_pkg::CHAR_MINUS;
      srde_pkg::OUT_DIGIT: out_char_o = srde_pkg::table_char(table_i, 4'(stk_q[0]));
      default:             out_char_o = srde_pkg::CHAR_NUL;
    endcase
  end

  `SRDE_ASSERT(a_pop_not_empty, clk_i, rst_ni, cmd_i.pop |-> cnt_q != '0)
  `SRDE_ASSERT(a_push_not_full, clk_i, rst_ni, cmd_i.push |-> cnt_q != CNT_W'(DEPTH))

endmodule

FILE: rtl/core/srde_ctrl.sv
`timescale 1ns / 1ps

`include "signed_radix_digit_emitter_macros.svh"

module srde_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic                 m_last_o,
  output logic                 m_bad_o,
  input  logic                 table_ok_i,
  input  srde_pkg::dp_status_t status_i,
  output srde_pkg::ctrl_cmd_t  cmd_o
);

  srde_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srde_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.out_sel = srde_pkg::OUT_ERR;
    s_ready_o     = 1'b0;
    m_valid_o     = 1'b0;
    m_last_o      = 1'b0;
    m_bad_o       = 1'b0;
    case (state_q)
      srde_pkg::ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = table_ok_i ? srde_pkg::ST_DIV : srde_pkg::ST_ERR;
        end
      end
      srde_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.last_pass) begin
          state_d = srde_pkg::ST_CHECK;
        end
      end
      srde_pkg::ST_CHECK: begin
        // The remainder of the finished division is the next digit.
        cmd_o.push = 1'b1;
        if (!status_i.quot_zero) begin
          state_d = srde_pkg::ST_DIV;
        end else if (status_i.neg) begin
          state_d = srde_pkg::ST_SIGN;
        end else begin
          state_d = srde_pkg::ST_DIGIT;
        end
      end
      srde_pkg::ST_SIGN: begin
        m_valid_o     = 1'b1;
        cmd_o.out_sel = srde_pkg::OUT_SIGN;
        if (m_ready_i) begin
          state_d = srde_pkg::ST_DIGIT;
        end
      end
      srde_pkg::ST_DIGIT: begin
        m_valid_o     = 1'b1;
        m_last_o      = status_i.cnt_one;
        cmd_o.out_sel = srde_pkg::OUT_DIGIT;
        if (m_ready_i) begin
          cmd_o.pop = 1'b1;
          if (status_i.cnt_one) begin
            state_d = srde_pkg::ST_IDLE;
          end
        end
      end
      srde_pkg::ST_ERR: begin
        m_valid_o = 1'b1;
        m_last_o  = 1'b1;
        m_bad_o   = 1'b1;
        if (m_ready_i) begin
          state_d = srde_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = srde_pkg::ST_IDLE;
      end
    endcase
  end

  `SRDE_ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, s_ready_o && m_valid_o)
  `SRDE_ASSERT(a_bad_is_last, clk_i, rst_ni, (m_valid_o && m_bad_o) |-> m_last_o)
  `SRDE_ASSERT(a_bad_table_err, clk_i, rst_ni,
               (s_valid_i && s_ready_o && !table_ok_i) |=> (m_valid_o && m_bad_o))

endmodule

FILE: rtl/core/signed_radix_digit_emitter.sv
`timescale 1ns / 1ps

// Channel   Direction  Fields
// s_axis    in         tdata: value
// m_axis    out        tdata: out_char; tlast: last_char; tuser: bad_base
// APB       in/out     radix at 0x00, digit_chars_low at 0x08, digit_chars_high at 0x10
//
// An item is loaded, then each digit takes PASSES division passes and a check step,
// where PASSES = ceil(VALUE_BITS/8): the divider retires eight quotient bits a cycle.
// The check pushes the remainder as the digit; then the sign and the digits come out.
// An invalid digit table gives a single error item right after the load.
// Output stalls hold the character; no new item is taken until the last goes.
// Reset restores radix 16 and the table "0123456789abcdef".

module signed_radix_digit_emitter #(
  parameter int MAX_RADIX  = srde_pkg::MAX_RADIX_DEF,
  parameter int VALUE_BITS = srde_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // value
  input  logic [((VALUE_BITS+7)/8)*8-1:0]  s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // out_char
  output logic [7:0]                       m_axis_tdata_o,
  output logic                             m_axis_tlast_o,
  // bad_base
  output logic                             m_axis_tuser_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [4:0]                       paddr,
  input  logic [srde_pkg::CHARS_W-1:0]     pwdata,
  output logic [srde_pkg::CHARS_W-1:0]     prdata,
  output logic                             pready
);

  logic [srde_pkg::RADIX_W-1:0] radix;
  logic [srde_pkg::TABLE_W-1:0] tbl;
  logic                         table_ok;
  srde_pkg::ctrl_cmd_t          cmd;
  srde_pkg::dp_status_t         status;

  srde_cfg #(
    .MAX_RADIX (MAX_RADIX)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .radix_o    (radix),
    .table_o    (tbl),
    .table_ok_o (table_ok)
  );

  srde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid_i),
    .s_ready_o  (s_axis_tready_o),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_last_o   (m_axis_tlast_o),
    .m_bad_o    (m_axis_tuser_o),
    .table_ok_i (table_ok),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srde_dpath #(
    .MAX_RADIX  (MAX_RADIX),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .value_i    (s_axis_tdata_i[VALUE_BITS-1:0]),
    .radix_i    (radix),
    .table_i    (tbl),
    .out_char_o (m_axis_tdata_o)
  );

endmodule

FILE: bench/signed_radix_digit_emitter_tb.sv
`timescale 1ns / 1ps

module signed_radix_digit_emitter_tb;
  import srde_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_SETTINGS = 10;
  localparam int ITEMS_PER_SETTING = 20;

  // The register file decodes paddr[4:3]; this index is not mapped.
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  localparam logic [4:0] ADDR_RADIX      = {REG_RADIX, 3'b000};
  localparam logic [4:0] ADDR_CHARS_LOW  = {REG_CHARS_LOW, 3'b000};
  localparam logic [4:0] ADDR_CHARS_HIGH = {REG_CHARS_HIGH, 3'b000};
  localparam logic [4:0] ADDR_UNMAPPED   = {REG_UNMAPPED, 3'b000};

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       bad;
  } text_char_t;

  typedef enum int {
    FAULT_LOW_RADIX,
    FAULT_HIGH_RADIX,
    FAULT_DUPLICATE,
    FAULT_SIGN_CHAR,
    FAULT_NUL_CHAR
  } table_fault_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  // Shadow copy of the register file.
  logic [4:0]  cfg_radix = RESET_RADIX;
  logic [63:0] cfg_chars_low = RESET_CHARS_LOW;
  logic [63:0] cfg_chars_high = RESET_CHARS_HIGH;

  logic [31:0] pending_values[$];
  text_char_t  text_q[$];
  int          errors = 0;
  int          s_gap = 0;
  int          s_calm = 0;
  int          m_stall = 0;
  int          m_calm = 0;
  int          quiet = 0;

  signed_radix_digit_emitter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  function automatic logic [7:0] digit_glyph(input int pos);
    logic [127:0] tbl;
    tbl = {cfg_chars_high, cfg_chars_low};
    return tbl[pos*8 +: 8];
  endfunction

  function automatic bit digit_set_ok();
    int r;
    int a;
    int b;
    logic [7:0] c;
    r = int'(cfg_radix);
    if (r < 2 || r > MAX_RADIX_DEF) return 1'b0;
    for (a = 0; a < r; a++) begin
      c = digit_glyph(a);
      if (c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS) return 1'b0;
      for (b = a + 1; b < r; b++) begin
        if (digit_glyph(b) == c) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Works out the characters printed for one value and queues them.
  function automatic void expect_text(input logic [31:0] raw);
    logic [31:0] mag;
    logic [31:0] base;
    int digs[32];
    int nd;
    int i;
    if (!digit_set_ok()) begin
      text_q.push_back('{ch: CHAR_NUL, last: 1'b1, bad: 1'b1});
      return;
    end
    base = 32'(cfg_radix);
    mag = raw[31] ? -raw : raw;
    nd = 0;
    do begin
      digs[nd] = int'(mag % base);
      nd++;
      mag = mag / base;
    end while (mag != 0);
    if (raw[31]) text_q.push_back('{ch: CHAR_MINUS, last: 1'b0, bad: 1'b0});
    for (i = nd - 1; i >= 0; i--) begin
      text_q.push_back('{ch: digit_glyph(digs[i]), last: (i == 0), bad: 1'b0});
    end
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_draw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] draw_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 40);
      1: return -$urandom_range(0, 40);
      2: return 32'h8000_0000 + $urandom_range(0, 3);
      3: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : feed
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_gap <= 0;
      s_calm <= 0;
    end else begin
      if (s_tvalid && s_tready) expect_text(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (s_gap != 0) begin
          s_gap <= s_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_values.size() != 0) begin
          s_tdata <= pending_values.pop_front();
          s_tvalid <= 1'b1;
          if (s_calm != 0) begin
            s_calm <= s_calm - 1;
            s_gap <= 0;
          end else begin
            s_gap <= idle_draw();
            if ($urandom_range(0, 24) == 0) s_calm <= $urandom_range(15, 50);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : sink
    text_char_t want;
    int stall_len;
    if (!rst_ni) begin
      m_tready <= 1'b0;
      m_stall <= 0;
      m_calm <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (text_q.size() == 0) begin
          errors++;
          $error("unexpected item: out_char %h last_char %b bad_base %b",
                 m_tdata, m_tlast, m_tuser);
        end else begin
          want = text_q.pop_front();
          if (m_tdata !== want.ch) begin
            errors++;
            $error("out_char: expected %h, got %h", want.ch, m_tdata);
          end
          if (m_tlast !== want.last) begin
            errors++;
            $error("last_char: expected %b, got %b", want.last, m_tlast);
          end
          if (m_tuser !== want.bad) begin
            errors++;
            $error("bad_base: expected %b, got %b", want.bad, m_tuser);
          end
        end
      end
      if (m_stall != 0) begin
        m_stall <= m_stall - 1;
        m_tready <= 1'b0;
      end else if (m_calm != 0) begin
        m_calm <= m_calm - 1;
        m_tready <= 1'b1;
      end else begin
        stall_len = idle_draw();
        if (stall_len != 0) begin
          m_tready <= 1'b0;
          m_stall <= stall_len - 1;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 24) == 0) m_calm <= $urandom_range(15, 50);
        end
      end
    end
  end

  // Ends the run if no handshake of any kind happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Must be called right after a rising edge.
  task automatic cfg_write(input logic [4:0] addr, input logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr[4:3])
      REG_RADIX:      cfg_radix = data[4:0];
      REG_CHARS_LOW:  cfg_chars_low = data;
      REG_CHARS_HIGH: cfg_chars_high = data;
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [4:0] r, input logic [63:0] lo,
                              input logic [63:0] hi);
    cfg_write(ADDR_RADIX, 64'(r));
    cfg_write(ADDR_CHARS_LOW, lo);
    cfg_write(ADDR_CHARS_HIGH, hi);
  endtask

  // Waits until every item is taken and every character has come out.
  task automatic drain();
    while (pending_values.size() != 0 || s_tvalid || text_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
  endtask

  // Builds a table of distinct printable-or-not characters, sometimes broken.
  task automatic draw_setting(output logic [4:0] r, output logic [63:0] lo,
                              output logic [63:0] hi, output bit ok);
    logic [127:0] tbl;
    logic [7:0] c;
    int pos;
    int j;
    bit clash;
    table_fault_e fault;
    case ($urandom_range(0, 3))
      0: r = 5'd2;
      1: r = 5'd16;
      default: r = 5'($urandom_range(2, 16));
    endcase
    tbl = {$urandom, $urandom, $urandom, $urandom};
    for (pos = 0; pos < r; pos++) begin
      do begin
        c = 8'($urandom);
        clash = (c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS);
        for (j = 0; j < pos; j++) begin
          if (tbl[j*8 +: 8] == c) clash = 1'b1;
        end
      end while (clash);
      tbl[pos*8 +: 8] = c;
    end
    ok = 1'b1;
    if ($urandom_range(0, 4) == 0) begin
      ok = 1'b0;
      fault = table_fault_e'($urandom_range(0, 4));
      case (fault)
        FAULT_LOW_RADIX:  r = 5'($urandom_range(0, 1));
        FAULT_HIGH_RADIX: r = 5'($urandom_range(17, 31));
        FAULT_DUPLICATE: begin
          pos = $urandom_range(1, r - 1);
          j = $urandom_range(0, pos - 1);
          tbl[pos*8 +: 8] = tbl[j*8 +: 8];
        end
        FAULT_SIGN_CHAR: begin
          tbl[$urandom_range(0, r - 1)*8 +: 8] = $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
        end
        default: tbl[$urandom_range(0, r - 1)*8 +: 8] = CHAR_NUL;
      endcase
    end
    lo = tbl[63:0];
    hi = tbl[127:64];
  endtask

  initial begin : stimulus
    logic [4:0]  r;
    logic [63:0] lo;
    logic [63:0] hi;
    bit          ok;
    int          s;
    int          k;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset base: hexadecimal with lowercase letters.
    @(negedge clk_i);
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd1);
    pending_values.push_back(32'hFFFF_FFFF);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'hAAAA_AAAA);
    pending_values.push_back(32'h5555_5555);
    pending_values.push_back(32'd255);
    pending_values.push_back(-32'd256);
    pending_values.push_back(32'h1234_5678);
    drain();

    // Binary: the most negative value gives the longest text.
    cfg_write(ADDR_RADIX, 64'd2);
    @(negedge clk_i);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(-32'd5);
    drain();

    // Decimal with letters; bytes past the radix hold junk that must be ignored.
    load_setting(5'd10, 64'h5857_5655_5453_5251, 64'hFF51_512D_2B00_5A59);
    @(negedge clk_i);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'd1234567890);
    drain();

    // A write to the unmapped index must leave the setting alone.
    cfg_write(ADDR_UNMAPPED, '1);
    @(negedge clk_i);
    pending_values.push_back(32'd42);
    drain();

    // Radix outside 2..16 with an otherwise good table.
    load_setting(5'd0, RESET_CHARS_LOW, RESET_CHARS_HIGH);
    @(negedge clk_i);
    pending_values.push_back(-32'd7);
    drain();
    cfg_write(ADDR_RADIX, 64'd1);
    @(negedge clk_i);
    pending_values.push_back(32'd7);
    drain();
    cfg_write(ADDR_RADIX, 64'd17);
    @(negedge clk_i);
    pending_values.push_back(32'h8000_0000);
    drain();
    cfg_write(ADDR_RADIX, '1);
    @(negedge clk_i);
    pending_values.push_back(32'd0);
    drain();

    // Broken tables: duplicate, plus sign, minus sign, zero byte.
    load_setting(5'd16, RESET_CHARS_LOW, 64'h3065_6463_6261_3938);
    @(negedge clk_i);
    pending_values.push_back(-32'd1);
    drain();
    cfg_write(ADDR_CHARS_LOW, 64'h3736_3534_3332_312B);
    cfg_write(ADDR_CHARS_HIGH, RESET_CHARS_HIGH);
    @(negedge clk_i);
    pending_values.push_back(32'd99);
    drain();
    cfg_write(ADDR_CHARS_LOW, RESET_CHARS_LOW);
    cfg_write(ADDR_CHARS_HIGH, 64'h2D65_6463_6261_3938);
    @(negedge clk_i);
    pending_values.push_back(32'h7FFF_FFFF);
    drain();
    load_setting(5'd10, RESET_CHARS_LOW, 64'h6665_6463_6261_0038);
    @(negedge clk_i);
    pending_values.push_back(32'd12345);
    drain();

    for (s = 0; s < RANDOM_SETTINGS; s++) begin
      draw_setting(r, lo, hi, ok);
      load_setting(r, lo, hi);
      @(negedge clk_i);
      for (k = 0; k < (ok ? ITEMS_PER_SETTING : 4); k++) begin
        pending_values.push_back(draw_value());
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (text_q.size() != 0) begin
      errors++;
      $error("%0d expected characters never arrived", text_q.size());
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: signed_radix_digit_emitter.f
+incdir+rtl/core
rtl/core/srde_pkg.sv
rtl/core/srde_cfg.sv
rtl/core/srde_dpath.sv
rtl/core/srde_ctrl.sv
rtl/core/signed_radix_digit_emitter.sv
bench/signed_radix_digit_emitter_tb.sv
